### src/sphit_pkg.sv
// Shared types, codes and constants of the sprite point hit test.
package sphit_pkg;

   localparam int COORD_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Quotient magnitude is held to 2^40, so 41 quotient bits cover it.
   localparam int QUOT_BITS = 41;
   localparam logic [QUOT_BITS-1:0] QUOT_LIMIT = QUOT_BITS'(1) << (QUOT_BITS - 1);

   localparam int CORDIC_ITERS = 30;
   localparam int XW           = 34;
   localparam int ZW           = 33;
   localparam int TRIG_W       = 32;
   localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POSITION     = 3'd0,
      CSR_ROTATION     = 3'd1,
      CSR_SET_SIZE     = 3'd2,
      CSR_TEXTURE_SIZE = 3'd3,
      CSR_DRAW_SCALE   = 3'd4,
      CSR_PIVOT        = 3'd5,
      CSR_FLAGS        = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_HIDDEN = 2'd1,
      ST_ZERO   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ANGLE,
      CS_ITER,
      CS_DONE
   } cordic_state_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_q28;
      logic signed [TRIG_W-1:0] sin_q28;
   } trig_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] a;
      begin
         case (i)
            5'd0:    a = 33'sd843314857;
            5'd1:    a = 33'sd497837829;
            5'd2:    a = 33'sd263043837;
            5'd3:    a = 33'sd133525159;
            5'd4:    a = 33'sd67021687;
            5'd5:    a = 33'sd33543516;
            5'd6:    a = 33'sd16775851;
            5'd7:    a = 33'sd8388437;
            5'd8:    a = 33'sd4194283;
            5'd9:    a = 33'sd2097149;
            5'd10:   a = 33'sd1048576;
            default: a = 33'sd1 <<< (5'd30 - i);
         endcase
         return a;
      end
   endfunction

endpackage

### src/sphit_if.sv
// Handshake channels of the sprite point hit test: query, result and register write.
interface sphit_req_if;
   logic valid;
   logic ready;
   logic signed [sphit_pkg::COORD_W-1:0] point_x;
   logic signed [sphit_pkg::COORD_W-1:0] point_y;
   modport source(output valid, output point_x, output point_y, input ready);
   modport sink(input valid, input point_x, input point_y, output ready);
endinterface

interface sphit_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   sphit_pkg::status_type status;
   logic signed [sphit_pkg::COORD_W-1:0] local_x;
   logic signed [sphit_pkg::COORD_W-1:0] local_y;
   modport source(output valid, output hit, output status, output local_x,
                  output local_y, input ready);
   modport sink(input valid, input hit, input status, input local_x,
                input local_y, output ready);
endinterface

interface sphit_csr_if;
   logic valid;
   logic ready;
   logic [sphit_pkg::CSR_INDEX_W-1:0] index;
   logic [sphit_pkg::CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### src/sphit_cordic.sv
// Sequential CORDIC that turns the rotation register into Q28 cosine and sine.
module sphit_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic                 busy,
   output sphit_pkg::trig_type  trig
);

   localparam int XW = sphit_pkg::XW;
   localparam int ZW = sphit_pkg::ZW;

   sphit_pkg::cordic_state_type state_ff, state_in;
   logic [4:0]            iter_ff;
   logic [1:0]            quad_ff;
   logic signed [XW-1:0]  x_ff, y_ff;
   logic signed [ZW-1:0]  z_ff;
   sphit_pkg::trig_type   trig_ff;

   logic signed [XW-1:0]  xs, ys, xr, yr, xr_rnd, yr_rnd;
   logic [63:0]           res_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sphit_pkg::CS_ANGLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sphit_pkg::CS_IDLE:  state_in = sphit_pkg::CS_IDLE;
         sphit_pkg::CS_ANGLE: state_in = sphit_pkg::CS_ITER;
         sphit_pkg::CS_ITER: begin
            if (iter_ff == 5'(sphit_pkg::CORDIC_ITERS - 1)) state_in = sphit_pkg::CS_DONE;
         end
         sphit_pkg::CS_DONE:  state_in = sphit_pkg::CS_IDLE;
         default:             state_in = sphit_pkg::CS_IDLE;
      endcase
      // A register write restarts the whole computation.
      if (start) state_in = sphit_pkg::CS_ANGLE;
   end

   assign res_prod = 64'(angle[ANGLE_BITS-3:0]) * sphit_pkg::TWO_PI_Q30;
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;

   always_comb begin
      case (quad_ff)
         2'd1: begin
            xr = -y_ff;
            yr = x_ff;
         end
         2'd2: begin
            xr = -x_ff;
            yr = -y_ff;
         end
         2'd3: begin
            xr = y_ff;
            yr = -x_ff;
         end
         default: begin
            xr = x_ff;
            yr = y_ff;
         end
      endcase
      xr_rnd = (xr + 34'sd2) >>> 2;
      yr_rnd = (yr + 34'sd2) >>> 2;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         sphit_pkg::CS_ANGLE: begin
            quad_ff <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            z_ff    <= ZW'(res_prod >> ANGLE_BITS);
            x_ff    <= sphit_pkg::CORDIC_GAIN_Q30;
            y_ff    <= '0;
            iter_ff <= '0;
         end
         sphit_pkg::CS_ITER: begin
            if (!z_ff[ZW-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - sphit_pkg::atan_q30(iter_ff);
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + sphit_pkg::atan_q30(iter_ff);
            end
            iter_ff <= iter_ff + 5'd1;
         end
         sphit_pkg::CS_DONE: begin
            trig_ff.cos_q28 <= sphit_pkg::TRIG_W'(xr_rnd);
            trig_ff.sin_q28 <= sphit_pkg::TRIG_W'(yr_rnd);
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != sphit_pkg::CS_IDLE);
   assign trig = trig_ff;

endmodule

### src/sphit_div.sv
// Pipelined restoring divider: one quotient bit per stage, 41 quotient bits and an overflow flag.
module sphit_div #(
   parameter int NW = 66,
   parameter int DW = 51
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [NW-1:0]                   n,
   input  logic [DW-1:0]                   d,
   input  logic                            neg_in,
   output logic [sphit_pkg::QUOT_BITS-1:0] q,
   output logic                            ovf,
   output logic                            neg_out
);

   localparam int QB = sphit_pkg::QUOT_BITS;
   localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

   logic [RW-1:0] rem_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];
   logic          neg_ff [QB+1];

   // The divisor comes from configuration; the user must hold it while items are in flight (not enforced here).
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(n);
         q_ff[0]   <= '0;
         ovf_ff[0] <= (RW'(n) >= (RW'(d) << QB));
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_stage
      localparam int BIT = QB - j;
      logic [RW:0] diff;

      assign diff = {1'b0, rem_ff[j-1]} - {1'b0, (RW'(d) << BIT)};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[RW]) begin
               rem_ff[j] <= diff[RW-1:0];
               q_ff[j]   <= q_ff[j-1] | (QB'(1) << BIT);
            end else begin
               rem_ff[j] <= rem_ff[j-1];
               q_ff[j]   <= q_ff[j-1];
            end
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign q       = q_ff[QB];
   assign ovf     = ovf_ff[QB];
   assign neg_out = neg_ff[QB];

endmodule

### src/sprite_point_hit_test.sv
// Sprite point hit test: maps each query point into the sprite's unit quad through the
// inverse of pivot, scale with flip, rotation and translation, and flags a hit when both
// local coordinates lie in 0..1. One item is accepted per cycle unless a finished result waits
// or the trig unit is busy; the depth is set by the 41-stage divider that forms u / width
// and v / height. The sine and cosine of the rotation come from a CORDIC that runs once after
// reset and again after every register write; while it runs no item is accepted (register
// writes are always taken).
module sprite_point_hit_test #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int ANGLE_BITS      = 16
) (
   input logic          clock,
   input logic          reset,
   sphit_req_if.sink    req_if,
   sphit_rsp_if.source  rsp_if,
   sphit_csr_if.sink    csr_if
);

   localparam int F     = COORD_FRAC_BITS;
   localparam int QB    = sphit_pkg::QUOT_BITS;
   localparam int SH_N  = (F > 20) ? F - 20 : 0;
   localparam int SH_D  = (F < 20) ? 20 - F : 0;
   localparam int BW    = (16 + F > 32) ? 16 + F : 32;
   localparam int WMW   = BW + 16;
   localparam int DW    = WMW + SH_D;
   localparam int UW    = 66;
   localparam int NW    = UW + SH_N;
   localparam int PIV_L = (F >= 12) ? F - 12 : 0;
   localparam int PIV_R = (F < 12) ? 12 - F : 0;
   localparam int SW    = QB + 2;
   localparam int LAT   = QB + 7;
   localparam logic signed [31:0] ONE = 32'sd1 <<< F;

   // Registers
   logic [63:0] position_ff, set_size_ff;
   logic [15:0] rotation_ff;
   logic [31:0] texture_ff, scale_ff, pivot_ff;
   logic [3:0]  flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         rotation_ff <= '0;
         set_size_ff <= '0;
         texture_ff  <= '0;
         scale_ff    <= 32'h0100_0100;
         pivot_ff    <= '0;
         flags_ff    <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (sphit_pkg::csr_index_type'(csr_if.index))
            sphit_pkg::CSR_POSITION:     position_ff <= csr_if.data;
            sphit_pkg::CSR_ROTATION:     rotation_ff <= csr_if.data[15:0];
            sphit_pkg::CSR_SET_SIZE:     set_size_ff <= csr_if.data;
            sphit_pkg::CSR_TEXTURE_SIZE: texture_ff  <= csr_if.data[31:0];
            sphit_pkg::CSR_DRAW_SCALE:   scale_ff    <= csr_if.data[31:0];
            sphit_pkg::CSR_PIVOT:        pivot_ff    <= csr_if.data[31:0];
            sphit_pkg::CSR_FLAGS:        flags_ff    <= csr_if.data[3:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // Effective size magnitudes and signs, settled well before the trig unit is done.
   logic [BW-1:0]  bw_x, bw_y;
   logic [15:0]    smag_x, smag_y;
   logic [WMW-1:0] wmag_x_ff, wmag_y_ff;
   logic           wneg_x_ff, wneg_y_ff;

   assign bw_x = (set_size_ff[31:0] != 32'd0) ? BW'(set_size_ff[31:0])
                                              : (BW'(texture_ff[15:0]) << F);
   assign bw_y = (set_size_ff[63:32] != 32'd0) ? BW'(set_size_ff[63:32])
                                               : (BW'(texture_ff[31:16]) << F);
   assign smag_x = scale_ff[15] ? 16'(-scale_ff[15:0]) : scale_ff[15:0];
   assign smag_y = scale_ff[31] ? 16'(-scale_ff[31:16]) : scale_ff[31:16];

   always_ff @(posedge clock) begin
      wmag_x_ff <= WMW'(bw_x) * WMW'(smag_x);
      wmag_y_ff <= WMW'(bw_y) * WMW'(smag_y);
      wneg_x_ff <= scale_ff[15] ^ flags_ff[2];
      wneg_y_ff <= scale_ff[31] ^ flags_ff[3];
   end

   sphit_pkg::status_type status_cfg;
   always_comb begin
      if (!flags_ff[0] || !flags_ff[1]) begin
         status_cfg = sphit_pkg::ST_HIDDEN;
      end else if (wmag_x_ff == '0 || wmag_y_ff == '0) begin
         status_cfg = sphit_pkg::ST_ZERO;
      end else begin
         status_cfg = sphit_pkg::ST_OK;
      end
   end

   // Rotation
   logic                trig_busy;
   sphit_pkg::trig_type trig;
   logic signed [31:0]  cos_q28, sin_q28;

   sphit_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (csr_if.valid && csr_if.ready),
      .angle (ANGLE_BITS'(rotation_ff)),
      .busy  (trig_busy),
      .trig  (trig)
   );

   assign cos_q28 = trig.cos_q28;
   assign sin_q28 = trig.sin_q28;

   // Pipeline control: the whole pipe advances unless a finished result waits.
   logic [LAT-1:0] valid_ff;
   logic           pipe_en;

   assign pipe_en      = !valid_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = pipe_en && !trig_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_if.valid && !trig_busy};
      end
   end

   // Translation, rotation products, their sums, then magnitudes for the divider.
   logic signed [32:0]   dx_ff, dy_ff;
   logic signed [64:0]   pxc_ff, pys_ff, pyc_ff, pxs_ff;
   logic signed [UW-1:0] u_ff, v_ff;
   logic [UW-1:0]        umag, vmag;
   logic [NW-1:0]        nu_ff, nv_ff;
   logic                 negu_ff, negv_ff;

   assign umag = u_ff[UW-1] ? UW'(-u_ff) : UW'(u_ff);
   assign vmag = v_ff[UW-1] ? UW'(-v_ff) : UW'(v_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dx_ff   <= 33'(req_if.point_x) - 33'($signed(position_ff[31:0]));
         dy_ff   <= 33'(req_if.point_y) - 33'($signed(position_ff[63:32]));
         pxc_ff  <= dx_ff * cos_q28;
         pys_ff  <= dy_ff * sin_q28;
         pyc_ff  <= dy_ff * cos_q28;
         pxs_ff  <= dx_ff * sin_q28;
         u_ff    <= UW'(pxc_ff) + UW'(pys_ff);
         v_ff    <= UW'(pyc_ff) - UW'(pxs_ff);
         nu_ff   <= NW'(umag) << SH_N;
         nv_ff   <= NW'(vmag) << SH_N;
         negu_ff <= u_ff[UW-1] ^ wneg_x_ff;
         negv_ff <= v_ff[UW-1] ^ wneg_y_ff;
      end
   end

   logic [QB-1:0] qx, qy;
   logic          ovfx, ovfy, negx, negy;

   sphit_div #(.NW(NW), .DW(DW)) u_div_x (
      .clock   (clock),
      .en      (pipe_en),
      .n       (nu_ff),
      .d       (DW'(wmag_x_ff) << SH_D),
      .neg_in  (negu_ff),
      .q       (qx),
      .ovf     (ovfx),
      .neg_out (negx)
   );

   sphit_div #(.NW(NW), .DW(DW)) u_div_y (
      .clock   (clock),
      .en      (pipe_en),
      .n       (nv_ff),
      .d       (DW'(wmag_y_ff) << SH_D),
      .neg_in  (negv_ff),
      .q       (qy),
      .ovf     (ovfy),
      .neg_out (negy)
   );

   // Clamp, sign, pivot offset and saturation.
   logic [QB-1:0]        magx, magy;
   logic signed [SW-1:0] sqx, sqy, pivx, pivy, sumx, sumy;
   logic signed [31:0]   lx_in, ly_in, lx_ff, ly_ff;

   assign magx = (ovfx || qx > sphit_pkg::QUOT_LIMIT) ? sphit_pkg::QUOT_LIMIT : qx;
   assign magy = (ovfy || qy > sphit_pkg::QUOT_LIMIT) ? sphit_pkg::QUOT_LIMIT : qy;
   assign sqx  = negx ? -$signed(SW'(magx)) : $signed(SW'(magx));
   assign sqy  = negy ? -$signed(SW'(magy)) : $signed(SW'(magy));
   assign pivx = (SW'($signed(pivot_ff[15:0])) <<< PIV_L) >>> PIV_R;
   assign pivy = (SW'($signed(pivot_ff[31:16])) <<< PIV_L) >>> PIV_R;
   assign sumx = sqx + pivx;
   assign sumy = sqy + pivy;

   always_comb begin
      if (sumx > SW'(32'sh7FFF_FFFF)) begin
         lx_in = 32'sh7FFF_FFFF;
      end else if (sumx < -SW'(33'sh0_8000_0000)) begin
         lx_in = 32'sh8000_0000;
      end else begin
         lx_in = 32'(sumx);
      end
      if (sumy > SW'(32'sh7FFF_FFFF)) begin
         ly_in = 32'sh7FFF_FFFF;
      end else if (sumy < -SW'(33'sh0_8000_0000)) begin
         ly_in = 32'sh8000_0000;
      end else begin
         ly_in = 32'(sumy);
      end
   end

   logic                  hit_ff;
   sphit_pkg::status_type status_ff;
   logic signed [31:0]    local_x_ff, local_y_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
         status_ff <= status_cfg;
         if (status_cfg == sphit_pkg::ST_OK) begin
            hit_ff     <= (lx_ff >= 32'sd0) && (lx_ff <= ONE) &&
                          (ly_ff >= 32'sd0) && (ly_ff <= ONE);
            local_x_ff <= lx_ff;
            local_y_ff <= ly_ff;
         end else begin
            hit_ff     <= 1'b0;
            local_x_ff <= '0;
            local_y_ff <= '0;
         end
      end
   end

   assign rsp_if.valid   = valid_ff[LAT-1];
   assign rsp_if.hit     = hit_ff;
   assign rsp_if.status  = status_ff;
   assign rsp_if.local_x = local_x_ff;
   assign rsp_if.local_y = local_y_ff;

   // A register write must hold off queries until the trig unit has rerun.
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_if.valid && csr_if.ready |=> !req_if.ready)
      else $error("query accepted right after a register write");

   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != sphit_pkg::ST_OK |->
         !rsp_if.hit && rsp_if.local_x == 32'sd0 && rsp_if.local_y == 32'sd0)
      else $error("untransformed item carries coordinates or a hit");

   a_hit_in_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.hit |->
         rsp_if.status == sphit_pkg::ST_OK && !rsp_if.local_x[31] &&
         !rsp_if.local_y[31] && rsp_if.local_x <= ONE && rsp_if.local_y <= ONE)
      else $error("hit reported outside the unit quad");

endmodule

### tb/sprite_point_hit_test_test.sv
// Testbench of the sprite point hit test: directed and random queries checked against a predictor.
`timescale 1ns / 100ps

module sprite_point_hit_test_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   typedef struct packed {
      logic                  hit;
      sphit_pkg::status_type status;
      logic signed [31:0]    local_x;
      logic signed [31:0]    local_y;
   } hit_result_type;

   typedef struct {
      int                    phase;
      logic [31:0]           point_x;
      logic [31:0]           point_y;
      bit                    typed;
      sphit_pkg::status_type status;
   } query_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sphit_req_if req_if();
   sphit_rsp_if rsp_if();
   sphit_csr_if csr_if();

   sprite_point_hit_test DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Local copy of the sprite registers.
   logic [63:0] sprite_position;
   logic [15:0] sprite_rotation;
   logic [63:0] sprite_set_size;
   logic [31:0] sprite_texture_size;
   logic [31:0] sprite_draw_scale;
   logic [31:0] sprite_pivot;
   logic [3:0]  sprite_flags;

   hit_result_type pending_hits[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int idle_cycles = 0;

   const longint atan_table[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                    33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

   task automatic sprite_trig(output longint cos_q28, output longint sin_q28);
      logic [1:0] quadrant;
      longint x, y, z, at, xs, ys, t;
      quadrant = sprite_rotation[15:14];
      z = longint'((64'(sprite_rotation[13:0]) * 64'd6746518852) >> 16);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         at = (i < 11) ? atan_table[i] : (longint'(1) << (30 - i));
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - at;
         end else begin
            x = x + ys; y = y - xs; z = z + at;
         end
      end
      case (quadrant)
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      cos_q28 = (x + 2) >>> 2;
      sin_q28 = (y + 2) >>> 2;
   endtask

   // Quotient of a numerator with 44 fraction bits over a size with 24, to 16 bits,
   // truncated toward zero and held to 2^40 in magnitude.
   function automatic longint scale_divide(longint num, longint den);
      bit neg;
      longint unsigned n, d, q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? longint'(-num) : num;
      d = (den < 0) ? longint'(-den) : den;
      d = d << 4;
      q = n / d;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint saturate32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic predict_hit(input logic [31:0] px, input logic [31:0] py,
                              output hit_result_type r);
      longint bw, bh, w, h, c, s, dx, dy, u, v, lx, ly, one;
      r = '{hit: 1'b0, status: sphit_pkg::ST_OK, local_x: '0, local_y: '0};
      if (!sprite_flags[0] || !sprite_flags[1]) begin
         r.status = sphit_pkg::ST_HIDDEN;
         return;
      end
      bw = longint'(sprite_set_size[31:0]);
      bh = longint'(sprite_set_size[63:32]);
      if (bw == 0) bw = longint'(sprite_texture_size[15:0]) << 16;
      if (bh == 0) bh = longint'(sprite_texture_size[31:16]) << 16;
      w = bw * longint'($signed(sprite_draw_scale[15:0]));
      h = bh * longint'($signed(sprite_draw_scale[31:16]));
      if (sprite_flags[2]) w = -w;
      if (sprite_flags[3]) h = -h;
      if (w == 0 || h == 0) begin
         r.status = sphit_pkg::ST_ZERO;
         return;
      end
      sprite_trig(c, s);
      dx = longint'($signed(px)) - longint'($signed(sprite_position[31:0]));
      dy = longint'($signed(py)) - longint'($signed(sprite_position[63:32]));
      u = dx * c + dy * s;
      v = dy * c - dx * s;
      lx = saturate32(scale_divide(u, w) + longint'($signed(sprite_pivot[15:0])) * 16);
      ly = saturate32(scale_divide(v, h) + longint'($signed(sprite_pivot[31:16])) * 16);
      one = 64'sd65536;
      r.hit = (lx >= 0 && lx <= one && ly >= 0 && ly <= one);
      r.local_x = lx[31:0];
      r.local_y = ly[31:0];
   endtask

   task automatic write_reg(input sphit_pkg::csr_index_type index, input logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (index)
         sphit_pkg::CSR_POSITION:     sprite_position     = data;
         sphit_pkg::CSR_ROTATION:     sprite_rotation     = data[15:0];
         sphit_pkg::CSR_SET_SIZE:     sprite_set_size     = data;
         sphit_pkg::CSR_TEXTURE_SIZE: sprite_texture_size = data[31:0];
         sphit_pkg::CSR_DRAW_SCALE:   sprite_draw_scale   = data[31:0];
         sphit_pkg::CSR_PIVOT:        sprite_pivot        = data[31:0];
         sphit_pkg::CSR_FLAGS:        sprite_flags        = data[3:0];
         default: ;
      endcase
   endtask

   task automatic write_sprite(input logic [63:0] pos, input logic [15:0] rot,
                               input logic [63:0] size, input logic [31:0] tex,
                               input logic [31:0] scale, input logic [31:0] piv,
                               input logic [3:0] flg);
      write_reg(sphit_pkg::CSR_POSITION, pos);
      write_reg(sphit_pkg::CSR_ROTATION, 64'(rot));
      write_reg(sphit_pkg::CSR_SET_SIZE, size);
      write_reg(sphit_pkg::CSR_TEXTURE_SIZE, 64'(tex));
      write_reg(sphit_pkg::CSR_DRAW_SCALE, 64'(scale));
      write_reg(sphit_pkg::CSR_PIVOT, 64'(piv));
      write_reg(sphit_pkg::CSR_FLAGS, 64'(flg));
   endtask

   task automatic wait_drained();
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   // Items are offered back to back; the valid line only drops during idle gaps.
   task automatic send_query(input logic [31:0] px, input logic [31:0] py, input bit typed,
                             input sphit_pkg::status_type st);
      hit_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.point_x <= px;
      req_if.point_y <= py;
      do @(posedge clock); while (!req_if.ready);
      if (typed) r = '{hit: 1'b0, status: st, local_x: '0, local_y: '0};
      else predict_hit(px, py, r);
      pending_hits.push_back(r);
   endtask

   task automatic directed_config(input int phase);
      case (phase)
         1: write_reg(sphit_pkg::CSR_FLAGS, 64'd3);
         2: write_reg(sphit_pkg::CSR_FLAGS, 64'd1);
         3: write_sprite(64'h0, 16'h0, 64'h0, 32'h0010_0010, 32'h0100_0100, 32'h0, 4'h3);
         4: write_sprite({32'h0010_0000, 32'hFFF0_0000}, 16'h4000, {32'h0008_0000, 32'h0},
                         32'h0020_0010, 32'hFF80_0200, 32'h0800_0800, 4'hF);
         5: write_sprite({32'h7FFF_FFFF, 32'h8000_0000}, 16'hFFFF, {32'h0000_0001, 32'h1},
                         32'hFFFF_FFFF, 32'h7FFF_8000, 32'h8000_7FFF, 4'h7);
         6: write_sprite(64'h0, 16'h2000, {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'h0,
                         32'h0001_0001, 32'hF000_F000, 4'hB);
         7: write_reg(sphit_pkg::CSR_DRAW_SCALE, 64'h0);
         default: ;
      endcase
   endtask

   task automatic random_sprite(input int kind);
      logic [63:0] pos, size;
      logic [31:0] tex, scale;
      logic [3:0]  flg;
      pos = {32'($signed(int'($urandom_range(8388607)) - 4194304)),
             32'($signed(int'($urandom_range(8388607)) - 4194304))};
      size = ($urandom_range(1) == 0) ? 64'h0 :
             {32'($urandom_range(32'h0040_0000, 32'h0000_8000)),
              32'($urandom_range(32'h0040_0000, 32'h0000_8000))};
      tex = {16'($urandom_range(64, 1)), 16'($urandom_range(64, 1))};
      scale = {16'($urandom_range(16'h0300, 16'h0040)), 16'($urandom_range(16'h0300, 16'h0040))};
      if ($urandom_range(1)) scale[31:16] = -scale[31:16];
      flg = {2'($urandom), 2'b11};
      if (kind == 0) begin
         pos = {$urandom, $urandom}; size = {$urandom, $urandom}; tex = $urandom;
         scale = $urandom; flg = 4'($urandom);
      end else if (kind == 1) begin
         pos = '1; size = '1; tex = '1; scale = '1; flg = '1;
      end else if (kind == 2) begin
         size = 64'h0; tex = '0;
      end else if ($urandom_range(9) == 0) begin
         flg = 4'($urandom);
      end
      write_sprite(pos, 16'($urandom), size, tex, scale, $urandom, flg);
   endtask

   const query_row_type directed_rows[] = '{
      '{0, 32'h0000_0000, 32'h0000_0000, 1'b1, sphit_pkg::ST_HIDDEN},
      '{0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, sphit_pkg::ST_HIDDEN},
      '{1, 32'h0001_0000, 32'h0001_0000, 1'b1, sphit_pkg::ST_ZERO},
      '{1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, sphit_pkg::ST_ZERO},
      '{2, 32'h0000_8000, 32'h0000_8000, 1'b1, sphit_pkg::ST_HIDDEN},
      '{3, 32'h0000_0000, 32'h0000_0000, 1'b0, sphit_pkg::ST_OK},
      '{3, 32'h0010_0000, 32'h0010_0000, 1'b0, sphit_pkg::ST_OK},
      '{3, 32'h0008_0000, 32'h0004_0000, 1'b0, sphit_pkg::ST_OK},
      '{3, 32'h0010_0001, 32'h0008_0000, 1'b0, sphit_pkg::ST_OK},
      '{3, 32'hFFFF_FFFF, 32'h0008_0000, 1'b0, sphit_pkg::ST_OK},
      '{3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, sphit_pkg::ST_OK},
      '{4, 32'hFFF0_0000, 32'h0010_0000, 1'b0, sphit_pkg::ST_OK},
      '{4, 32'hFFF4_0000, 32'h0014_0000, 1'b0, sphit_pkg::ST_OK},
      '{4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, sphit_pkg::ST_OK},
      '{5, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, sphit_pkg::ST_OK},
      '{5, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, sphit_pkg::ST_OK},
      '{5, 32'h0000_0000, 32'h0000_0000, 1'b0, sphit_pkg::ST_OK},
      '{6, 32'h0000_0000, 32'h0000_0000, 1'b0, sphit_pkg::ST_OK},
      '{6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, sphit_pkg::ST_OK},
      '{6, 32'h8000_0000, 32'h8000_0000, 1'b0, sphit_pkg::ST_OK},
      '{7, 32'h0001_0000, 32'h0001_0000, 1'b1, sphit_pkg::ST_ZERO}
   };

   // Result side: random stall, long hold-off on request, and the comparison.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_hits.size() == 0) begin
               $display("%0t: result with nothing expected: hit %0b status %0d x %0d y %0d",
                        $time, rsp_if.hit, rsp_if.status, rsp_if.local_x, rsp_if.local_y);
               error_count++;
            end else begin
               hit_result_type e;
               e = pending_hits.pop_front();
               if (rsp_if.hit !== e.hit || rsp_if.status !== e.status ||
                   rsp_if.local_x !== e.local_x || rsp_if.local_y !== e.local_y) begin
                  $display("%0t: expected hit %0b status %0d x %0d y %0d, got %0b %0d %0d %0d",
                           $time, e.hit, e.status, e.local_x, e.local_y, rsp_if.hit,
                           rsp_if.status, rsp_if.local_x, rsp_if.local_y);
                  error_count++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int phase;
      int send_modes[4] = '{0, 69, 0, 24};
      int stall_modes[4] = '{0, 0, 69, 24};
      logic [31:0] px, py;
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
      sprite_position = '0;
      sprite_rotation = '0;
      sprite_set_size = '0;
      sprite_texture_size = '0;
      sprite_draw_scale = 32'h0100_0100;
      sprite_pivot = '0;
      sprite_flags = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      phase = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].phase != phase) begin
            req_if.valid <= 1'b0;
            wait_drained();
            phase = directed_rows[i].phase;
            directed_config(phase);
         end
         send_query(directed_rows[i].point_x, directed_rows[i].point_y,
                    directed_rows[i].typed, directed_rows[i].status);
      end

      for (int p = 0; p < 17; p++) begin
         req_if.valid <= 1'b0;
         wait_drained();
         send_idle_pct = send_modes[p % 4];
         recv_stall_pct = stall_modes[p % 4];
         random_sprite(p < 3 ? p : 3);
         for (int n = 0; n < 100; n++) begin
            if (p == 4 && n == 10) hold_off_cycles = 300;
            if ($urandom_range(9) < 6) begin
               px = sprite_position[31:0] + 32'(int'($urandom_range(8388607)) - 4194304);
               py = sprite_position[63:32] + 32'(int'($urandom_range(8388607)) - 4194304);
            end else begin
               px = $urandom;
               py = $urandom;
            end
            send_query(px, py, 1'b0, sphit_pkg::ST_OK);
         end
      end
      req_if.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
